// ===== rtl/core/tesa_pkg.sv =====
// Shared types and constants for the tile edge shadow alpha unit.
// Holds the per-stage word formats of the divider, squarer and root chains.
// Depends on nothing.
package tesa_pkg;

   localparam int TILE_MAX   = 127;   // last pixel index of a 128 pixel tile
   localparam int DIV_STEPS  = 17;    // quotient bits of a Q1.16 ramp
   localparam int ROOT_STEPS = 16;    // result bits of a 32-bit square root
   localparam int NUM_REGS   = 3;

   localparam logic [16:0] Q_ONE = 17'h10000;

   // register indexes
   localparam logic [1:0] REG_SIDE   = 2'd0;
   localparam logic [1:0] REG_TOP    = 2'd1;
   localparam logic [1:0] REG_BOTTOM = 2'd2;

   // ramp lanes; each lane index equals its neighbor flag bit
   localparam int LANE_N = 0;
   localparam int LANE_E = 1;
   localparam int LANE_S = 2;
   localparam int LANE_W = 3;

   // root lanes: side norm, then the four corners
   localparam int ROOT_SIDE = 0;
   localparam int ROOT_NW   = 1;
   localparam int ROOT_NE   = 2;
   localparam int ROOT_SE   = 3;
   localparam int ROOT_SW   = 4;

   typedef struct packed {
      logic [7:0]        flags;
      logic [3:0][7:0]   rem;
      logic [3:0][16:0]  quo;
   } div_word_type;

   typedef struct packed {
      logic [7:0]        flags;
      logic [3:0][32:0]  rsq;   // squared ramp
      logic [3:0][32:0]  asq;   // squared complement of the ramp
   } sq_word_type;

   typedef struct packed {
      logic [3:0]        cflags;
      logic [4:0]        sat;
      logic [4:0][31:0]  val;
      logic [4:0][17:0]  rem;
      logic [4:0][15:0]  root;
   } root_word_type;

endpackage

// ===== rtl/core/tile_edge_shadow_alpha_unit.sv =====
// Tile edge shadow alpha unit: one pixel word in, one alpha word out.
// The path from the accepting edge to the first edge that can take the result
// runs through 17 divider cells, squaring, summing, 16 root cells, corner
// selection and the output register. One word per cycle unless rsp_ready
// stalls; each stage collapses bubbles on its own. Synchronous active-high reset
// empties the chain and loads the spreads 24 (side), 16 (top) and 32 (bottom).
module tile_edge_shadow_alpha_unit import tesa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [6:0]  req_pixel_x,
   input  logic [6:0]  req_pixel_y,
   input  logic [7:0]  req_neighbour_flags,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_shadow_alpha,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_data
);

   // ---------------- configuration registers ----------------
   logic [6:0] spread_side_ff, spread_top_ff, spread_bottom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spread_side_ff   <= 7'd24;
         spread_top_ff    <= 7'd16;
         spread_bottom_ff <= 7'd32;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SIDE:   spread_side_ff   <= csr_data;
            REG_TOP:    spread_top_ff    <= csr_data;
            REG_BOTTOM: spread_bottom_ff <= csr_data;
            default: ;  // drop writes past the last register
         endcase
      end
   end

   // ---------------- ramp setup ----------------
   // Lane spreads; a zero spread divides by one with a zero remainder, so
   // the ramp comes out zero.
   logic [3:0][6:0] spread;
   logic [3:0][6:0] divisor;
   logic [3:0][6:0] gap;
   div_word_type    div_head;

   always_comb begin
      spread[LANE_N] = spread_top_ff;
      spread[LANE_E] = spread_side_ff;
      spread[LANE_S] = spread_bottom_ff;
      spread[LANE_W] = spread_side_ff;
      gap[LANE_N]    = req_pixel_y;
      gap[LANE_E]    = 7'(TILE_MAX) - req_pixel_x;
      gap[LANE_S]    = 7'(TILE_MAX) - req_pixel_y;
      gap[LANE_W]    = req_pixel_x;
      div_head.flags = req_neighbour_flags;
      for (int l = 0; l < 4; l++) begin
         divisor[l] = (spread[l] == 7'd0) ? 7'd1 : spread[l];
         // remainder starts at spread - distance inside the ramp, else zero
         div_head.rem[l] = (gap[l] < spread[l]) ? {1'b0, spread[l] - gap[l]} : 8'd0;
         div_head.quo[l] = 17'd0;
      end
   end

   // ---------------- stall chain ----------------
   // Each stage advances when it is empty or its successor advances.
   logic [DIV_STEPS-1:0]  div_valid, div_adv;
   logic [ROOT_STEPS-1:0] root_valid, root_adv;
   logic sq_valid, sq_adv, sum_adv, post_adv, out_adv;
   logic sum_valid_ff, post_valid_ff, rsp_valid_ff;

   assign out_adv  = !rsp_valid_ff || rsp_ready;
   assign post_adv = !post_valid_ff || out_adv;
   assign sum_adv  = !sum_valid_ff || root_adv[0];
   assign sq_adv   = !sq_valid || sum_adv;
   assign root_adv[ROOT_STEPS-1] = !root_valid[ROOT_STEPS-1] || post_adv;
   assign div_adv[DIV_STEPS-1]   = !div_valid[DIV_STEPS-1] || sq_adv;
   assign req_ready = div_adv[0];

   // ---------------- divider row ----------------
   div_word_type div_data [DIV_STEPS];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      if (i < DIV_STEPS - 1) begin : g_link
         assign div_adv[i] = !div_valid[i] || div_adv[i+1];
      end
      if (i == 0) begin : g_first
         tesa_div_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .advance   (div_adv[i]),
            .in_valid  (req_valid),
            .in_data   (div_head),
            .divisor   (divisor),
            .out_valid (div_valid[i]),
            .out_data  (div_data[i])
         );
      end else begin : g_next
         tesa_div_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .advance   (div_adv[i]),
            .in_valid  (div_valid[i-1]),
            .in_data   (div_data[i-1]),
            .divisor   (divisor),
            .out_valid (div_valid[i]),
            .out_data  (div_data[i])
         );
      end
   end

   // ---------------- squares ----------------
   sq_word_type sq_data;

   tesa_square_stage u_square (
      .clock     (clock),
      .reset     (reset),
      .advance   (sq_adv),
      .in_valid  (div_valid[DIV_STEPS-1]),
      .in_data   (div_data[DIV_STEPS-1]),
      .out_valid (sq_valid),
      .out_data  (sq_data)
   );

   // ---------------- sums ----------------
   // Side: sum of enabled squared ramps. Corners: sum of the two squared
   // complements. Anything at or above one squared saturates the root.
   logic [34:0]      side_sum;
   logic [3:0][33:0] corner_sum;
   root_word_type    sum_in, sum_ff;

   always_comb begin
      side_sum = 35'd0;
      for (int l = 0; l < 4; l++) begin
         if (sq_data.flags[l]) begin
            side_sum = side_sum + {2'b00, sq_data.rsq[l]};
         end
      end
      corner_sum[0] = {1'b0, sq_data.asq[LANE_W]} + {1'b0, sq_data.asq[LANE_N]};
      corner_sum[1] = {1'b0, sq_data.asq[LANE_E]} + {1'b0, sq_data.asq[LANE_N]};
      corner_sum[2] = {1'b0, sq_data.asq[LANE_E]} + {1'b0, sq_data.asq[LANE_S]};
      corner_sum[3] = {1'b0, sq_data.asq[LANE_W]} + {1'b0, sq_data.asq[LANE_S]};
      sum_in.cflags = sq_data.flags[7:4];
      sum_in.sat[ROOT_SIDE] = |side_sum[34:32];
      sum_in.val[ROOT_SIDE] = side_sum[31:0];
      for (int k = 0; k < 4; k++) begin
         sum_in.sat[ROOT_NW + k] = |corner_sum[k][33:32];
         sum_in.val[ROOT_NW + k] = corner_sum[k][31:0];
      end
      for (int k = 0; k < 5; k++) begin
         sum_in.rem[k]  = 18'd0;
         sum_in.root[k] = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (sum_adv) begin
         sum_valid_ff <= sq_valid;
      end
      if (sum_adv) begin
         sum_ff <= sum_in;
      end
   end

   // ---------------- root row ----------------
   root_word_type root_data [ROOT_STEPS];

   for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
      if (i < ROOT_STEPS - 1) begin : g_link
         assign root_adv[i] = !root_valid[i] || root_adv[i+1];
      end
      if (i == 0) begin : g_first
         tesa_root_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .advance   (root_adv[i]),
            .in_valid  (sum_valid_ff),
            .in_data   (sum_ff),
            .out_valid (root_valid[i]),
            .out_data  (root_data[i])
         );
      end else begin : g_next
         tesa_root_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .advance   (root_adv[i]),
            .in_valid  (root_valid[i-1]),
            .in_data   (root_data[i-1]),
            .out_valid (root_valid[i]),
            .out_data  (root_data[i])
         );
      end
   end

   // ---------------- corner selection ----------------
   root_word_type    rt;
   logic [16:0]      side_in, best_in, side_ff, best_ff;
   logic [3:0][16:0] corner;
   logic [16:0]      max_a, max_b;

   assign rt = root_data[ROOT_STEPS-1];

   always_comb begin
      side_in = rt.sat[ROOT_SIDE] ? Q_ONE : {1'b0, rt.root[ROOT_SIDE]};
      for (int k = 0; k < 4; k++) begin
         // a saturated distance leaves no corner shadow
         corner[k] = (rt.cflags[k] && !rt.sat[ROOT_NW + k])
                   ? (Q_ONE - {1'b0, rt.root[ROOT_NW + k]}) : 17'd0;
      end
      max_a   = (corner[0] > corner[1]) ? corner[0] : corner[1];
      max_b   = (corner[2] > corner[3]) ? corner[2] : corner[3];
      best_in = (max_a > max_b) ? max_a : max_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_valid_ff <= 1'b0;
      end else if (post_adv) begin
         post_valid_ff <= root_valid[ROOT_STEPS-1];
      end
      if (post_adv) begin
         side_ff <= side_in;
         best_ff <= best_in;
      end
   end

   // ---------------- output register ----------------
   // Scale each value by 255/65536 and merge the bytes.
   logic [24:0] side_scaled, best_scaled;
   logic [7:0]  alpha_in, alpha_ff;

   assign side_scaled = {side_ff, 8'd0} - {8'd0, side_ff};
   assign best_scaled = {best_ff, 8'd0} - {8'd0, best_ff};
   assign alpha_in    = side_scaled[23:16] | best_scaled[23:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= post_valid_ff;
      end
      if (out_adv) begin
         alpha_ff <= alpha_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_shadow_alpha = alpha_ff;

endmodule

// ===== rtl/core/tesa_div_cell.sv =====
// One restoring division step for the four ramp lanes.
// Uses the word formats of tesa_pkg.
module tesa_div_cell import tesa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  div_word_type      in_data,
   input  logic [3:0][6:0]   divisor,
   output logic              out_valid,
   output div_word_type      out_data
);

   logic          valid_ff;
   div_word_type  data_ff;
   div_word_type  data_in;
   logic [3:0]    qbit;
   logic [3:0][7:0] diff;

   always_comb begin
      data_in.flags = in_data.flags;
      for (int l = 0; l < 4; l++) begin
         qbit[l] = in_data.rem[l] >= {1'b0, divisor[l]};
         diff[l] = qbit[l] ? (in_data.rem[l] - {1'b0, divisor[l]}) : in_data.rem[l];
         data_in.rem[l] = {diff[l][6:0], 1'b0};
         data_in.quo[l] = {in_data.quo[l][15:0], qbit[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/tesa_square_stage.sv =====
// Squares each ramp and its complement to one.
// Uses the word formats of tesa_pkg.
module tesa_square_stage import tesa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  div_word_type  in_data,
   output logic          out_valid,
   output sq_word_type   out_data
);

   logic            valid_ff;
   sq_word_type     data_ff;
   sq_word_type     data_in;
   logic [3:0][16:0] comp;

   always_comb begin
      data_in.flags = in_data.flags;
      for (int l = 0; l < 4; l++) begin
         comp[l] = Q_ONE - in_data.quo[l];
         data_in.rsq[l] = 33'(in_data.quo[l] * in_data.quo[l]);
         data_in.asq[l] = 33'(comp[l] * comp[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/tesa_root_cell.sv =====
// One digit step of the square root for the five root lanes.
// Uses the word formats of tesa_pkg.
module tesa_root_cell import tesa_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           in_valid,
   input  root_word_type  in_data,
   output logic           out_valid,
   output root_word_type  out_data
);

   logic            valid_ff;
   root_word_type   data_ff;
   root_word_type   data_in;
   logic [4:0][19:0] rem_t;
   logic [4:0][19:0] trial;
   logic [4:0][19:0] diff;
   logic [4:0]       ge;

   always_comb begin
      data_in.cflags = in_data.cflags;
      data_in.sat    = in_data.sat;
      for (int l = 0; l < 5; l++) begin
         rem_t[l] = {in_data.rem[l], in_data.val[l][31:30]};
         trial[l] = {2'b00, in_data.root[l], 2'b01};
         ge[l]    = rem_t[l] >= trial[l];
         diff[l]  = rem_t[l] - trial[l];
         data_in.rem[l]  = ge[l] ? diff[l][17:0] : rem_t[l][17:0];
         data_in.root[l] = {in_data.root[l][14:0], ge[l]};
         data_in.val[l]  = {in_data.val[l][29:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
